FILE: hw/rtl/aabbfc_pkg.sv
// ----------------------------------------------------------------------------
// aabbfc_pkg
// shared constants and types for the box versus frustum classifier
// ----------------------------------------------------------------------------
package aabbfc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_PLANES      = 6;
  localparam int NUM_CORNERS     = 8;
  localparam int NUM_AXES        = 3;

  // packed plane register layout: nx, ny, nz (q1.14) then d (q8.8)
  localparam int PLANE_W     = 64;
  localparam int NORMAL_W    = 16;
  localparam int OFFSET_W    = 16;
  localparam int NX_LSB      = 0;
  localparam int NY_LSB      = 16;
  localparam int NZ_LSB      = 32;
  localparam int D_LSB       = 48;
  localparam int OFFSET_FRAC = 14;  // q8.8 offset raised to q.22

  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PLANE_0 = 3'd0,
    REG_PLANE_1 = 3'd1,
    REG_PLANE_2 = 3'd2,
    REG_PLANE_3 = 3'd3,
    REG_PLANE_4 = 3'd4,
    REG_PLANE_5 = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VIS_OUT       = 2'd0,
    VIS_IN        = 2'd1,
    VIS_INTERSECT = 2'd2
  } vis_t;

  // per plane summary of the eight corner tests
  typedef struct packed {
    logic all_front;
    logic none_front;
  } plane_flags_t;

endpackage

FILE: hw/rtl/aabbfc_plane_test.sv
// ----------------------------------------------------------------------------
// aabbfc_plane_test
// tests the eight corners of one box against one plane
// ----------------------------------------------------------------------------
module aabbfc_plane_test #(
  parameter int COORD_WIDTH = aabbfc_pkg::COORD_WIDTH_DEF
) (
  input  logic [aabbfc_pkg::PLANE_W-1:0] plane,
  input  logic signed [COORD_WIDTH-1:0]  lo [aabbfc_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]  hi [aabbfc_pkg::NUM_AXES],
  output aabbfc_pkg::plane_flags_t       flags
);

  localparam int NW     = aabbfc_pkg::NORMAL_W;
  localparam int OW     = aabbfc_pkg::OFFSET_W;
  localparam int PROD_W = NW + COORD_WIDTH;
  localparam int D_W    = OW + aabbfc_pkg::OFFSET_FRAC;
  localparam int SUM_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

  logic signed [NW-1:0]     nrm [aabbfc_pkg::NUM_AXES];
  logic signed [OW-1:0]     d;
  logic signed [PROD_W-1:0] p_lo [aabbfc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] p_hi [aabbfc_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]  e_lo [aabbfc_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]  e_hi [aabbfc_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]  d_ext;
  logic [aabbfc_pkg::NUM_CORNERS-1:0] front;

  assign nrm[0] = plane[aabbfc_pkg::NX_LSB +: NW];
  assign nrm[1] = plane[aabbfc_pkg::NY_LSB +: NW];
  assign nrm[2] = plane[aabbfc_pkg::NZ_LSB +: NW];
  assign d      = plane[aabbfc_pkg::D_LSB +: OW];

  assign d_ext = {{(SUM_W-D_W){d[OW-1]}}, d, {aabbfc_pkg::OFFSET_FRAC{1'b0}}};

  // the dot product is linear, so two products per axis cover all corners
  for (genvar a = 0; a < aabbfc_pkg::NUM_AXES; a++) begin : g_axis
    assign p_lo[a] = nrm[a] * lo[a];
    assign p_hi[a] = nrm[a] * hi[a];
    assign e_lo[a] = {{(SUM_W-PROD_W){p_lo[a][PROD_W-1]}}, p_lo[a]};
    assign e_hi[a] = {{(SUM_W-PROD_W){p_hi[a][PROD_W-1]}}, p_hi[a]};
  end

  for (genvar c = 0; c < aabbfc_pkg::NUM_CORNERS; c++) begin : g_corner
    logic signed [SUM_W-1:0] margin;
    assign margin = (((c & 1) != 0) ? e_hi[0] : e_lo[0])
                  + (((c & 2) != 0) ? e_hi[1] : e_lo[1])
                  + (((c & 4) != 0) ? e_hi[2] : e_lo[2])
                  - d_ext;
    // in front (outside) when distance is not negative
    assign front[c] = ~margin[SUM_W-1];
  end

  assign flags.all_front  = &front;
  assign flags.none_front = ~|front;

endmodule

FILE: hw/rtl/aabb_frustum_classify_unit.sv
// ----------------------------------------------------------------------------
// aabb_frustum_classify_unit
// classifies axis-aligned boxes against six frustum planes (corner test)
// ----------------------------------------------------------------------------
// the done strobe comes out of the result register, which follows the input
//   register that takes a request
// throughput: one box per cycle; busy is low except during reset
// reset: synchronous rst clears the pipeline valid bits and all planes to
//   zero, so every box classifies as outside until planes are written
// the receiver cannot stall: each result is shown for exactly one cycle
module aabb_frustum_classify_unit #(
  parameter int COORD_WIDTH = aabbfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request side
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       box_min_x,
  input  logic signed [COORD_WIDTH-1:0]       box_min_y,
  input  logic signed [COORD_WIDTH-1:0]       box_min_z,
  input  logic signed [COORD_WIDTH-1:0]       box_max_x,
  input  logic signed [COORD_WIDTH-1:0]       box_max_y,
  input  logic signed [COORD_WIDTH-1:0]       box_max_z,
  // result side
  output logic                                done,
  output logic [1:0]                          visibility,
  // plane register writes
  input  logic                                cfg_wr_en,
  input  logic [aabbfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [aabbfc_pkg::PLANE_W-1:0]      cfg_wr_data
);

  localparam int NP = aabbfc_pkg::NUM_PLANES;
  localparam int NA = aabbfc_pkg::NUM_AXES;

  logic [aabbfc_pkg::PLANE_W-1:0] planes [NP];

  // input register stage
  logic                         s1_valid;
  logic signed [COORD_WIDTH-1:0] lo [NA];
  logic signed [COORD_WIDTH-1:0] hi [NA];

  aabbfc_pkg::plane_flags_t flags [NP];
  logic [NP-1:0]            all_front;
  logic [NP-1:0]            none_front;
  aabbfc_pkg::vis_t         vis_next;
  logic                     accept;

  // no backpressure: requests are refused only while in reset
  assign busy   = rst;
  assign accept = start && !busy;

  // plane registers, writes beyond the last plane fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NP; p++) begin
        planes[p] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        aabbfc_pkg::REG_PLANE_0: planes[0] <= cfg_wr_data;
        aabbfc_pkg::REG_PLANE_1: planes[1] <= cfg_wr_data;
        aabbfc_pkg::REG_PLANE_2: planes[2] <= cfg_wr_data;
        aabbfc_pkg::REG_PLANE_3: planes[3] <= cfg_wr_data;
        aabbfc_pkg::REG_PLANE_4: planes[4] <= cfg_wr_data;
        aabbfc_pkg::REG_PLANE_5: planes[5] <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // capture the box
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo[0] <= box_min_x;
      lo[1] <= box_min_y;
      lo[2] <= box_min_z;
      hi[0] <= box_max_x;
      hi[1] <= box_max_y;
      hi[2] <= box_max_z;
    end
  end

  // one corner tester per plane, all in parallel
  for (genvar p = 0; p < NP; p++) begin : g_plane
    aabbfc_plane_test #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_plane_test (
      .plane (planes[p]),
      .lo    (lo),
      .hi    (hi),
      .flags (flags[p])
    );
    assign all_front[p]  = flags[p].all_front;
    assign none_front[p] = flags[p].none_front;
  end

  // outside if any plane has every corner in front, inside if no corner
  // is in front of any plane, otherwise straddling
  always_comb begin
    if (|all_front) begin
      vis_next = aabbfc_pkg::VIS_OUT;
    end else if (&none_front) begin
      vis_next = aabbfc_pkg::VIS_IN;
    end else begin
      vis_next = aabbfc_pkg::VIS_INTERSECT;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      visibility <= vis_next;
    end
  end

`ifndef SYNTHESIS
  a_req_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("request did not produce a result two cycles later");

  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result strobe without a matching request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((all_front & none_front) == '0))
    else $error("plane reports all corners and no corners in front");
`endif

endmodule

FILE: bench/aabb_frustum_classify_checker.sv
// ----------------------------------------------------------------------------
// aabb_frustum_classify_checker
// watches the request, result and plane write ports of the box classifier,
// predicts the visibility of every accepted box and compares it in order
// ----------------------------------------------------------------------------
module aabb_frustum_classify_checker
  import aabbfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  input  logic                          done,
  input  logic [1:0]                    visibility,
  input  logic                          cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [PLANE_W-1:0]            cfg_wr_data,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding
);

  typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] axes_t;

  // shadow copy of the plane registers
  logic [PLANE_W-1:0] frustum [NUM_PLANES];
  // visibility owed for each request in flight, oldest first
  vis_t vis_owed_q [$];

  // exact corner test: q1.14 normal times q8.8 coordinate gives q.22,
  // the q8.8 offset is lifted to q.22 before the compare
  function automatic vis_t classify_box(axes_t lo, axes_t hi);
    longint nx, ny, nz, d, dot;
    longint pt [NUM_AXES];
    int     front;
    int     clear_planes;
    bit     culled;
    clear_planes = 0;
    culled       = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      nx    = longint'($signed(frustum[p][NX_LSB +: NORMAL_W]));
      ny    = longint'($signed(frustum[p][NY_LSB +: NORMAL_W]));
      nz    = longint'($signed(frustum[p][NZ_LSB +: NORMAL_W]));
      d     = longint'($signed(frustum[p][D_LSB +: OFFSET_W]));
      front = 0;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        for (int a = 0; a < NUM_AXES; a++)
          pt[a] = c[a] ? longint'($signed(hi[a])) : longint'($signed(lo[a]));
        dot = nx * pt[0] + ny * pt[1] + nz * pt[2] - d * (longint'(1) << OFFSET_FRAC);
        if (dot >= 0) front++;
      end
      if (front == NUM_CORNERS) culled = 1'b1;
      if (front == 0) clear_planes++;
    end
    if (culled) return VIS_OUT;
    if (clear_planes == NUM_PLANES) return VIS_IN;
    return VIS_INTERSECT;
  endfunction

  always @(posedge clk) begin
    vis_t want;
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) frustum[p] = '0;
      vis_owed_q.delete();
    end else begin
      // writes beyond the last plane are dropped
      if (cfg_wr_en && cfg_addr < NUM_PLANES) frustum[cfg_addr] = cfg_wr_data;
      if (done) begin
        if (vis_owed_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting, got visibility %0d",
                   $time, visibility);
        end else begin
          want = vis_owed_q.pop_front();
          if (visibility !== want) begin
            mismatches++;
            $display("%0t: visibility mismatch, expected %s (%0d), got %0d",
                     $time, want.name(), want, visibility);
          end
        end
      end
      if (start && !busy)
        vis_owed_q.push_back(classify_box({box_min_z, box_min_y, box_min_x},
                                          {box_max_z, box_max_y, box_max_x}));
    end
    outstanding = vis_owed_q.size();
  end

endmodule

FILE: bench/tb_aabb_frustum_classify_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_frustum_classify_unit
// stimulus and verdict for the box versus frustum classifier: directed boxes
// around the plane boundaries and the coordinate extremes, then random boxes
// under several plane sets; a checker beside the block does the prediction
// ----------------------------------------------------------------------------
module tb_aabb_frustum_classify_unit;
  import aabbfc_pkg::*;

  localparam int CW           = COORD_WIDTH_DEF;
  // well above the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;
  // result register sits behind the input register, leave some margin
  localparam int TAIL_CYCLES  = 8;
  localparam int UNIT_NORMAL  = 16384;  // 1.0 in q1.14
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_BOXES  = 100;
  localparam int SPARE_ADDRS  = 2 ** CFG_ADDR_W;

  typedef logic [NUM_AXES-1:0][CW-1:0] corner_t;

  // how a random phase fills the six plane registers
  typedef enum {
    FR_CUBE,     // axis aligned planes at +-h, a plain box shaped volume
    FR_TILTED,   // same outline with skewed normals
    FR_RAW,      // any 64 bit pattern
    FR_EXTREME,  // fields at their most negative / most positive / zero / all ones
    FR_CLEAR     // all planes zero again
  } frustum_kind_t;

  logic    clk         = 1'b0;
  logic    rst         = 1'b1;
  logic    start       = 1'b0;
  corner_t box_lo      = '0;
  corner_t box_hi      = '0;
  logic    cfg_wr_en   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
  logic [PLANE_W-1:0]    cfg_wr_data = '0;

  logic        busy;
  logic        done;
  logic [1:0]  visibility;
  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned        cycle_count = 0;
  bit                 quiet       = 1'b0;  // sender never idles while set
  logic [PLANE_W-1:0] plane_set [NUM_PLANES];

  always #6 clk = ~clk;

  aabb_frustum_classify_unit #(.COORD_WIDTH(CW)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .box_min_x   (box_lo[0]),
    .box_min_y   (box_lo[1]),
    .box_min_z   (box_lo[2]),
    .box_max_x   (box_hi[0]),
    .box_max_y   (box_hi[1]),
    .box_max_z   (box_hi[2]),
    .done        (done),
    .visibility  (visibility),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  aabb_frustum_classify_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .box_min_x   (box_lo[0]),
    .box_min_y   (box_lo[1]),
    .box_min_z   (box_lo[2]),
    .box_max_x   (box_hi[0]),
    .box_max_y   (box_hi[1]),
    .box_max_z   (box_hi[2]),
    .done        (done),
    .visibility  (visibility),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // q8.8 point, x in the low slice
  function automatic corner_t pt(int x, int y, int z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {d[OFFSET_W-1:0], nz[NORMAL_W-1:0], ny[NORMAL_W-1:0], nx[NORMAL_W-1:0]};
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // planes come in pairs per axis: even index faces +axis, odd faces -axis
  function automatic void choose_frustum(frustum_kind_t kind, int h);
    int extremes [4] = '{-32768, 32767, 0, -1};
    int n [NUM_AXES];
    for (int p = 0; p < NUM_PLANES; p++) begin
      case (kind)
        FR_CUBE, FR_TILTED: begin
          for (int a = 0; a < NUM_AXES; a++)
            n[a] = (kind == FR_TILTED) ? int'($urandom_range(0, UNIT_NORMAL)) - UNIT_NORMAL / 2
                                       : 0;
          n[p / 2] = p[0] ? -UNIT_NORMAL : UNIT_NORMAL;
          plane_set[p] = pack_plane(n[0], n[1], n[2],
                                    h + ((kind == FR_TILTED) ? int'($urandom_range(0, 255)) : 0));
        end
        FR_RAW:
          plane_set[p] = {$urandom, $urandom};
        FR_EXTREME:
          plane_set[p] = pack_plane(extremes[$urandom_range(3)], extremes[$urandom_range(3)],
                                    extremes[$urandom_range(3)], extremes[$urandom_range(3)]);
        default:
          plane_set[p] = '0;
      endcase
    end
    // make sure the widest values land in the registers every time
    if (kind == FR_EXTREME) begin
      plane_set[0] = pack_plane(32767, 32767, 32767, -32768);
      plane_set[1] = pack_plane(-32768, -32768, -32768, 32767);
      plane_set[2] = '1;
    end
  endfunction

  // random box around the volume of size h, with some swapped, wild and
  // extreme corners mixed in
  function automatic void pick_box(int h, output corner_t lo, output corner_t hi);
    int extremes [4] = '{-32768, 32767, 0, -1};
    int mix;
    int c, e, a_val, b_val;
    mix = $urandom_range(99);
    for (int a = 0; a < NUM_AXES; a++) begin
      c = int'($urandom_range(0, 4 * h)) - 2 * h;
      e = $urandom_range(0, h);
      if (mix < 60) begin
        a_val = clamp_coord(c - e);
        b_val = clamp_coord(c + e);
      end else if (mix < 75) begin
        // min above max, the block must not reorder
        a_val = clamp_coord(c + e);
        b_val = clamp_coord(c - e);
      end else if (mix < 90) begin
        a_val = int'($urandom_range(0, 65535)) - 32768;
        b_val = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        a_val = extremes[$urandom_range(3)];
        b_val = extremes[$urandom_range(3)];
      end
      lo[a] = a_val[CW-1:0];
      hi[a] = b_val[CW-1:0];
    end
  endfunction

  // one request; start stays high when the next request follows at once
  task automatic send_box(input corner_t lo, input corner_t hi);
    while (!quiet && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    box_lo <= lo;
    box_hi <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // writes plane_set, then optionally junk to the unused indexes above the
  // last plane, which the block has to drop
  task automatic load_planes(input bit with_spare);
    for (int p = 0; p < NUM_PLANES; p++) begin
      cfg_wr_en   <= 1'b1;
      cfg_addr    <= cfg_reg_t'(p);
      cfg_wr_data <= plane_set[p];
      @(posedge clk);
    end
    if (with_spare) begin
      for (int s = NUM_PLANES; s < SPARE_ADDRS; s++) begin
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_ADDR_W'(s);
        cfg_wr_data <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    frustum_kind_t phase_kind  [NUM_PHASES] = '{FR_CUBE, FR_TILTED, FR_CUBE, FR_RAW,
                                                FR_TILTED, FR_EXTREME, FR_CUBE, FR_CLEAR};
    int            phase_scale [NUM_PHASES] = '{256, 2048, 8192, 4096, 512, 1024, 64, 512};
    corner_t       lo, hi;
    int            h;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // planes still at reset: zero planes put every corner in front, so all out
    send_box(pt(0, 0, 0), pt(0, 0, 0));
    send_box(pt(-32768, -32768, -32768), pt(32767, 32767, 32767));
    send_box(pt(32767, -1, 256), pt(-32768, 1, -256));
    drain();

    // cube of half size 4.0, plus junk written to the indexes past the planes
    h = 1024;
    choose_frustum(FR_CUBE, h);
    load_planes(1'b1);
    send_box(pt(-256, -256, -256), pt(256, 256, 256));          // well inside
    send_box(pt(256, 256, 256), pt(-256, -256, -256));          // inside, min above max
    send_box(pt(h + 256, -256, -256), pt(h + 512, 256, 256));   // beyond +x
    send_box(pt(-256, -256, -h - 512), pt(256, 256, -h - 256)); // beyond -z
    send_box(pt(-256, -256, -256), pt(h + 256, 256, 256));      // straddles +x
    send_box(pt(h + 256, 256, 256), pt(-256, -256, -256));      // straddles, swapped
    send_box(pt(-2 * h, -2 * h, -2 * h), pt(2 * h, 2 * h, 2 * h)); // encloses the volume
    send_box(pt(h, -256, -256), pt(h + 256, 256, 256));         // touches +x from outside
    send_box(pt(-256, -256, -256), pt(h, 256, 256));            // one face on the plane
    send_box(pt(-256, -256, -256), pt(h - 1, 256, 256));        // just short of the plane
    send_box(pt(0, 0, 0), pt(0, 0, 0));                         // single point at center
    send_box(pt(-32768, -32768, -32768), pt(32767, 32767, 32767));
    send_box(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768));
    send_box(pt(32767, 32767, 32767), pt(32767, 32767, 32767));
    drain();

    // widest register contents against the coordinate extremes
    choose_frustum(FR_EXTREME, h);
    load_planes(1'b0);
    send_box(pt(-32768, -32768, -32768), pt(32767, 32767, 32767));
    send_box(pt(32767, 32767, 32767), pt(32767, 32767, 32767));
    send_box(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768));
    send_box(pt(0, 0, 0), pt(-1, -1, -1));
    drain();

    // random phases, each under its own plane set
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      h = phase_scale[ph];
      choose_frustum(phase_kind[ph], h);
      load_planes(ph[0]);
      // one long stretch where the sender never idles
      quiet = (ph == 2);
      for (int i = 0; i < PHASE_BOXES; i++) begin
        // hold off once mid phase until all results are back
        if (ph == 4 && i == PHASE_BOXES / 2) drain();
        pick_box(h, lo, hi);
        send_box(lo, hi);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
